>>> rtl/ksel_pkg.sv
// ============================================================================
// ksel_pkg
// Shared codes and fixed field widths for the k-smallest heap selector.
// ============================================================================
package ksel_pkg;

    localparam int MODE_W = 2;
    localparam int KEEP_W = 7;

    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFFER   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READOUT = 2'd2;

    localparam logic KIND_BOUND = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

endpackage

>>> rtl/k_smallest_max_heap_select.sv
// ============================================================================
// k_smallest_max_heap_select
// Keeps the k entries with the smallest distances in a bounded max-heap
// held in one synchronous RAM; reports the pruning bound and reads out.
// ============================================================================
// Flow: start, unused mode and empty readout return straight to idle; an
//   appended or dropped offer goes straight to the bound; a root replace
//   sifts down level by level; the filling offer first heapifies each node.
// Throughput: one item at a time; single-port heap RAM, at most two child
//   reads per sift level; readout reads, then emits each held item. Result stalls hold the flow.
// Reset: synchronous, active low; heap emptied (RAM not cleared), k = depth.
module k_smallest_max_heap_select
    import ksel_pkg::*;
#(
    parameter int HEAP_DEPTH = 32,
    parameter int ID_BITS    = 20,
    parameter int DIST_BITS  = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata, low bit up: keep_count[6:0], entry_id, distance, zero fill
    input  logic [((KEEP_W+ID_BITS+DIST_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [MODE_W-1:0]   s_axis_tuser,
    // result item stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata, low bit up: out_id, out_distance, zero fill
    output logic [((ID_BITS+DIST_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: kind
    output logic                m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CH_W   = IDX_W + 2;
    localparam int ENT_W  = ID_BITS + DIST_BITS;
    localparam int OUT_W  = ((ENT_W + 7) / 8) * 8;

    // control states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SD_L   = 4'd1;  // issue left child read
    localparam logic [3:0] ST_SD_R   = 4'd2;  // latch left, issue right read
    localparam logic [3:0] ST_SD_CMP = 4'd3;  // compare, write one level
    localparam logic [3:0] ST_HP_RD  = 4'd4;  // heapify: read node
    localparam logic [3:0] ST_HP_LD  = 4'd5;  // heapify: load node as mover
    localparam logic [3:0] ST_BOUND  = 4'd6;  // emit bound for an offer
    localparam logic [3:0] ST_RO_RD  = 4'd7;  // readout: read entry
    localparam logic [3:0] ST_RO_OUT = 4'd8;  // readout: emit entry

    // heap RAM: {id, distance} per entry, distance in the low bits
    logic [ENT_W-1:0]     mem [HEAP_DEPTH];
    logic [ENT_W-1:0]     r_rd_data;

    logic [3:0]           r_state;
    logic [CNT_W-1:0]     r_held;
    logic [CNT_W-1:0]     r_target;
    logic [IDX_W-1:0]     r_pos;        // current hole of the sift-down
    logic [ENT_W-1:0]     r_mover;      // entry being sifted down
    logic [ENT_W-1:0]     r_left;       // left child entry
    logic                 r_l_ok;
    logic                 r_r_ok;
    logic                 r_heapify;
    logic [IDX_W-1:0]     r_hidx;
    logic [CNT_W-1:0]     r_k;          // readout index
    logic [DIST_BITS-1:0] r_root_dist;  // copy of the root distance

    logic                 r_ovalid;
    logic                 r_okind;
    logic                 r_olast;
    logic [ID_BITS-1:0]   r_oid;
    logic [DIST_BITS-1:0] r_odist;

    // input fields
    logic [MODE_W-1:0]    w_mode;
    logic [KEEP_W-1:0]    w_keep;
    logic [ID_BITS-1:0]   w_id;
    logic [DIST_BITS-1:0] w_dist;
    logic                 w_in_acc;

    // RAM ports
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [ENT_W-1:0]     w_wdata;
    logic                 w_re;
    logic [IDX_W-1:0]     w_raddr;

    // sift-down helpers
    logic [CH_W-1:0]      w_lft;
    logic [CH_W-1:0]      w_rgt;
    logic [CH_W-1:0]      w_tgt_ext;
    logic [DIST_BITS-1:0] w_mv_dist;
    logic [DIST_BITS-1:0] w_l_dist;
    logic [DIST_BITS-1:0] w_r_dist;
    logic                 w_l_big;
    logic [DIST_BITS-1:0] w_win_dist;
    logic                 w_r_big;

    logic [CNT_W-1:0]     w_target_in;
    logic [CNT_W-1:0]     w_held_inc;
    logic [CNT_W-1:0]     w_hstart;
    logic [CNT_W-1:0]     w_k_inc;
    logic                 w_oslot;
    logic                 w_emit;
    logic                 w_full;

    assign w_mode   = s_axis_tuser;
    assign w_keep   = s_axis_tdata[KEEP_W-1:0];
    assign w_id     = s_axis_tdata[KEEP_W +: ID_BITS];
    assign w_dist   = s_axis_tdata[KEEP_W+ID_BITS +: DIST_BITS];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_oslot    = !r_ovalid || m_axis_tready;
    // a result item is loaded into the output register this cycle
    assign w_emit     = ((r_state == ST_BOUND) || (r_state == ST_RO_OUT)) && w_oslot;
    assign w_full     = (r_held == r_target);
    assign w_held_inc = r_held + CNT_W'(1);
    assign w_k_inc    = r_k + CNT_W'(1);
    assign w_hstart   = (r_target >> 1) - CNT_W'(1);

    // keep count saturates to the depth; zero acts as one
    always_comb begin
        if (w_keep > KEEP_W'(HEAP_DEPTH)) begin
            w_target_in = CNT_W'(HEAP_DEPTH);
        end else if (w_keep == '0) begin
            w_target_in = CNT_W'(1);
        end else begin
            w_target_in = CNT_W'(w_keep);
        end
    end

    // children of the hole: 2*pos+1 and 2*pos+2
    assign w_lft     = {1'b0, r_pos, 1'b1};
    assign w_rgt     = w_lft + CH_W'(1);
    assign w_tgt_ext = CH_W'(r_target);

    // left first, then right, each on a strictly greater distance
    assign w_mv_dist  = r_mover[DIST_BITS-1:0];
    assign w_l_dist   = r_left[DIST_BITS-1:0];
    assign w_r_dist   = r_rd_data[DIST_BITS-1:0];
    assign w_l_big    = r_l_ok && (w_l_dist > w_mv_dist);
    assign w_win_dist = w_l_big ? w_l_dist : w_mv_dist;
    assign w_r_big    = r_r_ok && (w_r_dist > w_win_dist);

    // RAM access control: never a read and a write in the same cycle
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_mover;
        w_re    = 1'b0;
        w_raddr = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_mode == MODE_OFFER && !w_full) begin
                    w_we    = 1'b1;
                    w_waddr = r_held[IDX_W-1:0];
                    w_wdata = {w_id, w_dist};
                end
            end
            ST_SD_L: begin
                if (w_lft < w_tgt_ext) begin
                    w_re    = 1'b1;
                    w_raddr = w_lft[IDX_W-1:0];
                end else begin
                    w_we = 1'b1;  // leaf: mover settles here
                end
            end
            ST_SD_R: begin
                w_re    = r_r_ok;
                w_raddr = w_rgt[IDX_W-1:0];
            end
            ST_SD_CMP: begin
                w_we = 1'b1;
                if (w_r_big) begin
                    w_wdata = r_rd_data;
                end else if (w_l_big) begin
                    w_wdata = r_left;
                end
            end
            ST_HP_RD: begin
                w_re    = 1'b1;
                w_raddr = r_hidx;
            end
            ST_RO_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
        if (w_we && w_waddr == '0) begin
            r_root_dist <= w_wdata[DIST_BITS-1:0];
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_held    <= '0;
            r_target  <= CNT_W'(HEAP_DEPTH);
            r_heapify <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        priority if (w_mode == MODE_START) begin
                            r_target <= w_target_in;
                            r_held   <= '0;
                        end else if (w_mode == MODE_OFFER) begin
                            if (!w_full) begin
                                r_held <= w_held_inc;
                                if (w_held_inc == r_target && r_target > CNT_W'(1)) begin
                                    r_heapify <= 1'b1;
                                    r_hidx    <= w_hstart[IDX_W-1:0];
                                    r_state   <= ST_HP_RD;
                                end else begin
                                    r_heapify <= 1'b0;
                                    r_state   <= ST_BOUND;
                                end
                            end else if (w_dist < r_root_dist) begin
                                r_heapify <= 1'b0;
                                r_mover   <= {w_id, w_dist};
                                r_pos     <= '0;
                                r_state   <= ST_SD_L;
                            end else begin
                                r_state <= ST_BOUND;
                            end
                        end else if (w_mode == MODE_READOUT) begin
                            r_k <= '0;
                            if (r_held != '0) begin
                                r_state <= ST_RO_RD;
                            end
                        end
                    end
                end
                ST_SD_L: begin
                    r_l_ok <= (w_lft < w_tgt_ext);
                    r_r_ok <= (w_rgt < w_tgt_ext);
                    if (w_lft < w_tgt_ext) begin
                        r_state <= ST_SD_R;
                    end else if (r_heapify && r_hidx != '0) begin
                        r_hidx  <= r_hidx - IDX_W'(1);
                        r_state <= ST_HP_RD;
                    end else begin
                        r_state <= ST_BOUND;
                    end
                end
                ST_SD_R: begin
                    r_left  <= r_rd_data;
                    r_state <= ST_SD_CMP;
                end
                ST_SD_CMP: begin
                    if (w_r_big) begin
                        r_pos   <= w_rgt[IDX_W-1:0];
                        r_state <= ST_SD_L;
                    end else if (w_l_big) begin
                        r_pos   <= w_lft[IDX_W-1:0];
                        r_state <= ST_SD_L;
                    end else if (r_heapify && r_hidx != '0) begin
                        r_hidx  <= r_hidx - IDX_W'(1);
                        r_state <= ST_HP_RD;
                    end else begin
                        r_state <= ST_BOUND;
                    end
                end
                ST_HP_RD: begin
                    r_state <= ST_HP_LD;
                end
                ST_HP_LD: begin
                    r_mover <= r_rd_data;
                    r_pos   <= r_hidx;
                    r_state <= ST_SD_L;
                end
                ST_BOUND: begin
                    if (w_oslot) begin
                        r_okind  <= KIND_BOUND;
                        r_olast  <= 1'b1;
                        r_oid    <= '0;
                        r_odist  <= w_full ? r_root_dist : '1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_RO_RD: begin
                    r_state <= ST_RO_OUT;
                end
                ST_RO_OUT: begin
                    if (w_oslot) begin
                        r_okind  <= KIND_ENTRY;
                        r_olast  <= (w_k_inc == r_held);
                        r_oid    <= r_rd_data[DIST_BITS +: ID_BITS];
                        r_odist  <= r_rd_data[DIST_BITS-1:0];
                        r_k      <= w_k_inc;
                        r_state  <= (w_k_inc == r_held) ? ST_IDLE : ST_RO_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = OUT_W'({r_odist, r_oid});

endmodule

>>> rtl/ksel_checker.sv
// ============================================================================
// ksel_checker
// Port-level checks for the k-smallest heap selector.
// ============================================================================
module ksel_checker
    import ksel_pkg::*;
#(
    parameter int ID_BITS   = 20,
    parameter int DIST_BITS = 48
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [((KEEP_W+ID_BITS+DIST_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic [MODE_W-1:0]   s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [((ID_BITS+DIST_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic                m_axis_tuser,
    input logic                m_axis_tlast
);

    // a bound item is always the single, last item of its offer
    a_bound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_BOUND) |-> m_axis_tlast)
        else $error("bound item without tlast");

    // a bound item carries a zero id
    a_bound_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_BOUND)
            |-> (m_axis_tdata[ID_BITS-1:0] == '0))
        else $error("bound item with nonzero id");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // after a start or unused-mode item the input is ready again in the next cycle
    a_start_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready
            && s_axis_tuser != MODE_OFFER && s_axis_tuser != MODE_READOUT)
            |=> s_axis_tready)
        else $error("start item stalled input");

endmodule

bind k_smallest_max_heap_select ksel_checker #(
    .ID_BITS   (ID_BITS),
    .DIST_BITS (DIST_BITS)
) u_ksel_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/ksel_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ksel_result_checker
// Watches both streams of the heap selector, keeps its own copy of the
// bounded max-heap, and compares every result item with the oldest one due.
// ============================================================================
module ksel_result_checker
    import ksel_pkg::*;
#(
    parameter int HEAP_DEPTH = 32,
    parameter int ID_BITS    = 20,
    parameter int DIST_BITS  = 48,
    parameter int IN_W       = 80,
    parameter int OUT_W      = 72
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side: tdata keep_count, entry_id, distance; tuser mode
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [IN_W-1:0]   i_req_data,
    input  logic [MODE_W-1:0] i_req_mode,
    // result side: tdata out_id, out_distance; tuser kind
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [OUT_W-1:0]  i_res_data,
    input  logic              i_res_kind,
    input  logic              i_res_last,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic                 kind;
        logic [ID_BITS-1:0]   id;
        logic [DIST_BITS-1:0] distance;
        logic                 last;
    } t_heap_out;

    logic [ID_BITS-1:0]   kept_ids   [HEAP_DEPTH];
    logic [DIST_BITS-1:0] kept_dists [HEAP_DEPTH];
    int unsigned          fill_count;
    int unsigned          keep_target;
    t_heap_out            results_due [$];
    int                   fails = 0;

    // max-heap on distance; left child wins a tie with the right one
    function automatic void sift_down_from(int unsigned start);
        int unsigned          pos;
        int unsigned          lft;
        int unsigned          rgt;
        int unsigned          big;
        logic [ID_BITS-1:0]   id_t;
        logic [DIST_BITS-1:0] dist_t;
        bit                   settled;
        pos     = start;
        settled = 1'b0;
        while (!settled) begin
            lft = 2 * pos + 1;
            rgt = lft + 1;
            big = pos;
            if (lft < keep_target && kept_dists[lft] > kept_dists[big]) big = lft;
            if (rgt < keep_target && kept_dists[rgt] > kept_dists[big]) big = rgt;
            if (big == pos) begin
                settled = 1'b1;
            end else begin
                dist_t           = kept_dists[pos];
                kept_dists[pos]  = kept_dists[big];
                kept_dists[big]  = dist_t;
                id_t             = kept_ids[pos];
                kept_ids[pos]    = kept_ids[big];
                kept_ids[big]    = id_t;
                pos              = big;
            end
        end
    endfunction

    function automatic void predict_request(logic [MODE_W-1:0] mode,
                                            logic [KEEP_W-1:0] keep,
                                            logic [ID_BITS-1:0] id,
                                            logic [DIST_BITS-1:0] distance);
        t_heap_out   r;
        int unsigned k;
        case (mode)
            MODE_START: begin
                k = 32'(keep);
                if (k > HEAP_DEPTH) k = HEAP_DEPTH;
                if (k == 0) k = 1;
                keep_target = k;
                fill_count  = 0;
            end
            MODE_OFFER: begin
                if (fill_count < keep_target) begin
                    kept_ids[fill_count]   = id;
                    kept_dists[fill_count] = distance;
                    fill_count++;
                    // just filled: bottom-up heapify
                    if (fill_count == keep_target) begin
                        for (k = keep_target / 2; k > 0; k--) sift_down_from(k - 1);
                    end
                end else if (distance < kept_dists[0]) begin
                    kept_ids[0]   = id;
                    kept_dists[0] = distance;
                    sift_down_from(0);
                end
                r.kind     = KIND_BOUND;
                r.id       = '0;
                r.distance = (fill_count < keep_target) ? '1 : kept_dists[0];
                r.last     = 1'b1;
                results_due.push_back(r);
            end
            MODE_READOUT: begin
                for (k = 0; k < fill_count; k++) begin
                    r.kind     = KIND_ENTRY;
                    r.id       = kept_ids[k];
                    r.distance = kept_dists[k];
                    r.last     = (k + 1 == fill_count);
                    results_due.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_heap_out seen;
        t_heap_out want;
        if (!i_rst_n) begin
            fill_count  = 0;
            keep_target = HEAP_DEPTH;
            results_due.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_mode,
                                i_req_data[KEEP_W-1:0],
                                i_req_data[KEEP_W +: ID_BITS],
                                i_req_data[KEEP_W+ID_BITS +: DIST_BITS]);
            end
            if (i_res_valid && i_res_ready) begin
                seen.kind     = i_res_kind;
                seen.id       = i_res_data[ID_BITS-1:0];
                seen.distance = i_res_data[ID_BITS +: DIST_BITS];
                seen.last     = i_res_last;
                if (results_due.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected result kind=%0d id=%h dist=%h last=%0d",
                                 $realtime, seen.kind, seen.id, seen.distance, seen.last);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (seen !== want) begin
                        if (fails < 10) begin
                            $display("%0t: result mismatch exp kind=%0d id=%h dist=%h last=%0d",
                                     $realtime, want.kind, want.id, want.distance,
                                     want.last);
                            $display("%0t:                 got kind=%0d id=%h dist=%h last=%0d",
                                     $realtime, seen.kind, seen.id, seen.distance,
                                     seen.last);
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

>>> tb/tb_k_smallest_max_heap_select.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_k_smallest_max_heap_select
// Drives start, offer and readout items into the heap selector with random
// gaps on both streams and one long result stall; the checker beside the
// block predicts every bound and held entry and counts mismatches.
// ============================================================================
module tb_k_smallest_max_heap_select;
    import ksel_pkg::*;

    localparam int HEAP_DEPTH   = 32;
    localparam int ID_BITS      = 20;
    localparam int DIST_BITS    = 48;
    localparam int IN_W         = ((KEEP_W + ID_BITS + DIST_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((ID_BITS + DIST_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 400;   // long result stall, fills the block
    localparam int DRAIN_CYCLES = 400;   // covers a full heapify at depth 32
    localparam int CYCLE_LIMIT  = 8_000_000;

    // mode code the block must ignore
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [IN_W-1:0]   s_data  = '0;   // keep_count, entry_id, distance, zero fill
    logic [MODE_W-1:0] s_mode  = '0;   // mode
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [OUT_W-1:0]  m_data;         // out_id, out_distance, zero fill
    logic              m_kind;         // kind
    logic              m_last;

    int fail_count;
    int pending;
    int items_sent  = 0;   // ignored mode items are left out of this
    int cycle_count = 0;

    logic req_taken = 1'b0;   // handshake seen at the last rising edge
    logic rx_hold   = 1'b0;
    bit   tx_burst  = 1'b0;   // no sender gaps while set

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    k_smallest_max_heap_select #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .ID_BITS    (ID_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_mode),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_kind),
        .m_axis_tlast  (m_last)
    );

    ksel_result_checker #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .ID_BITS    (ID_BITS),
        .DIST_BITS  (DIST_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_ready),
        .i_req_data   (s_data),
        .i_req_mode   (s_mode),
        .i_res_valid  (m_valid),
        .i_res_ready  (m_ready),
        .i_res_data   (m_data),
        .i_res_kind   (m_kind),
        .i_res_last   (m_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sampled at the edge so the sender never races the block's tready
    always @(posedge clk) begin
        req_taken <= s_valid && s_ready;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_k_smallest_max_heap_select: done, errors");
            $finish;
        end
    end

    // Result-side readiness. Alternates between stretches of steady
    // readiness and stretches of random stalls, mostly short, a few long.
    int rx_stall_left = 0;
    int rx_phase_left = 0;
    bit rx_choppy     = 1'b0;
    int rx_pick;

    always @(negedge clk) begin
        if (rx_phase_left == 0) begin
            rx_choppy     = 1'($urandom_range(0, 1));
            rx_phase_left = $urandom_range(50, 200);
        end else begin
            rx_phase_left = rx_phase_left - 1;
        end
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else if (!rx_choppy) begin
            m_ready <= 1'b1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 55) begin
                m_ready <= 1'b1;
            end else if (rx_pick < 93) begin
                m_ready <= 1'b0;
                rx_stall_left = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                rx_stall_left = $urandom_range(15, 60);
            end
        end
    end

    // One long hold-off in the middle of the random part. The sender keeps
    // offering, so the result path backs up and tready on the input drops.
    initial begin
        wait (items_sent >= 150);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // Sender gap before an item: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_burst || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Distances: plenty of small values so ties and drops happen often,
    // a few extremes, the rest spread over all bits.
    function automatic logic [DIST_BITS-1:0] pick_dist();
        logic [63:0] wide;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 35) wide = 64'($urandom_range(0, 15));
        else if (r < 38) wide = '0;
        else if (r < 41) wide = '1;
        else wide = {$urandom, $urandom};
        return wide[DIST_BITS-1:0];
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        logic [31:0] w;
        w = $urandom;
        return w[ID_BITS-1:0];
    endfunction

    function automatic logic [KEEP_W-1:0] pick_keep();
        logic [31:0] w;
        w = $urandom;
        return w[KEEP_W-1:0];
    endfunction

    // Present one item at the falling edge and hold it until it is taken.
    // tvalid stays high across back-to-back items.
    task automatic send_request(input logic [MODE_W-1:0]    mode,
                                input logic [KEEP_W-1:0]    keep,
                                input logic [ID_BITS-1:0]   id,
                                input logic [DIST_BITS-1:0] distance);
        logic [IN_W-1:0] word;
        int              gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word                               = '0;
        word[KEEP_W-1:0]                   = keep;
        word[KEEP_W +: ID_BITS]            = id;
        word[KEEP_W+ID_BITS +: DIST_BITS]  = distance;
        s_valid <= 1'b1;
        s_data  <= word;
        s_mode  <= mode;
        @(negedge clk);
        while (!req_taken) @(negedge clk);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    // A well-formed selection: start with some keep count, a run of offers
    // that fills the heap and then tests the root, readouts along the way.
    task automatic run_selection();
        int keep_raw;
        int k_eff;
        int n_offers;
        int r;
        r        = $urandom_range(0, 99);
        tx_burst = ($urandom_range(0, 3) == 0);
        if (r < 8) keep_raw = $urandom_range(0, 127);
        else if (r < 16) keep_raw = HEAP_DEPTH;
        else keep_raw = $urandom_range(1, 10);
        k_eff = (keep_raw > HEAP_DEPTH) ? HEAP_DEPTH : ((keep_raw == 0) ? 1 : keep_raw);
        send_request(MODE_START, keep_raw[KEEP_W-1:0], pick_id(), pick_dist());
        n_offers = $urandom_range(0, 3 * k_eff + 2);
        repeat (n_offers) begin
            send_request(MODE_OFFER, pick_keep(), pick_id(), pick_dist());
            if ($urandom_range(0, 9) == 0)
                send_request(MODE_READOUT, pick_keep(), pick_id(), pick_dist());
        end
        if ($urandom_range(0, 9) != 0)
            send_request(MODE_READOUT, pick_keep(), pick_id(), pick_dist());
    endtask

    initial begin
        int target;
        logic [MODE_W-1:0] noise_mode;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // empty heap: readout and the unused mode give nothing
        send_request(MODE_READOUT, '0, '0, '0);
        send_request(MODE_UNUSED, '1, '1, '1);
        // reset keep count is the full depth, so this bound stays all ones
        send_request(MODE_OFFER, '0, '1, '1);
        // keep count zero acts as one; then a tie against the root is dropped
        send_request(MODE_START, '0, '1, '1);
        send_request(MODE_OFFER, '1, '0, '0);
        send_request(MODE_OFFER, '0, 20'd5, '0);
        send_request(MODE_READOUT, '0, '0, '0);
        // oversize keep counts saturate to the depth
        send_request(MODE_START, 7'd127, '0, '0);
        send_request(MODE_START, 7'd64, '0, '0);
        // three held, heapify, replace root, sift-down, drop equal and larger
        send_request(MODE_START, 7'd3, '0, '0);
        send_request(MODE_OFFER, '0, 20'd1, 48'd7);
        send_request(MODE_OFFER, '0, 20'd2, 48'd9);
        send_request(MODE_OFFER, '0, 20'd3, 48'd4);
        send_request(MODE_OFFER, '0, 20'd4, 48'd9);
        send_request(MODE_OFFER, '0, 20'd5, 48'd4);
        send_request(MODE_OFFER, '0, 20'd6, '1);
        send_request(MODE_READOUT, '0, '0, '0);
        // children tie during heapify: the left one is taken
        send_request(MODE_START, 7'd3, '0, '0);
        send_request(MODE_OFFER, '0, 20'd7, 48'd1);
        send_request(MODE_OFFER, '0, 20'd8, 48'd5);
        send_request(MODE_OFFER, '0, 20'd9, 48'd5);
        send_request(MODE_READOUT, '0, '0, '0);

        // --- random ---
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                run_selection();
            end else begin
                tx_burst   = 1'b0;
                noise_mode = MODE_W'($urandom_range(0, 3));
                send_request(noise_mode, pick_keep(), pick_id(), pick_dist());
            end
        end
        s_valid <= 1'b0;

        // drain, then give a stray late result time to show up
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_k_smallest_max_heap_select: done, clean");
        end else begin
            $display("tb_k_smallest_max_heap_select: done, errors");
        end
        $finish;
    end

endmodule
